// ----- src/tefc_pkg.sv -----
package tefc_pkg;

  typedef enum logic [1:0] {
    FMT_F32 = 2'd0,
    FMT_F16 = 2'd1,
    FMT_I8  = 2'd2,
    FMT_RSV = 2'd3
  } fmt_e;

  localparam int unsigned ElemW = 32;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 2;

  localparam logic [CfgAddrW-1:0] RegSrcFmt = 1'd0;
  localparam logic [CfgAddrW-1:0] RegDstFmt = 1'd1;

  localparam logic [7:0] F32ExpBias = 8'd127;
  localparam logic [7:0] BiasDiff   = 8'd112;

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             clamped;
  } result_t;

  // Code 3 is treated as float32.
  function automatic fmt_e norm_fmt(input logic [1:0] code);
    fmt_e f;
    f = fmt_e'(code);
    if (f == FMT_RSV) begin
      f = FMT_F32;
    end
    return f;
  endfunction

endpackage

// ----- src/tefc_elem_if.sv -----
interface tefc_elem_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tefc_res_if.sv -----
interface tefc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_out;
  logic        clamped;

  modport source (output valid, output element_out, output clamped, input ready);
  modport sink (input valid, input element_out, input clamped, output ready);
endinterface

// ----- src/tensor_element_format_converter.sv -----
// Element format converter: float32, float16 and int8, via float32 unless
// the formats match. One element per cycle unless the output stalls, via
// an input register and a result register; the datapath between them sets
// the clock. The user writes formats only while idle; nothing enforces it.
module tensor_element_format_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tefc_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [tefc_pkg::CfgDataW-1:0] cfg_data_i,
  tefc_elem_if.sink                     in_if,
  tefc_res_if.source                    out_if
);
  import tefc_pkg::*;

  logic [1:0]  src_q, dst_q;
  logic        s1_vld_q, s2_vld_q;
  logic [31:0] s1_raw_q;
  result_t     conv, s2_q;
  fmt_e        src, dst;
  logic        s2_free, s1_free;

  assign src = norm_fmt(src_q);
  assign dst = norm_fmt(dst_q);

  assign s2_free     = !s2_vld_q || out_if.ready;
  assign s1_free     = !s1_vld_q || s2_free;
  assign in_if.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= 2'd0;
      dst_q <= 2'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSrcFmt) src_q <= cfg_data_i;
      else if (cfg_idx_i == RegDstFmt) dst_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_free) s1_vld_q <= in_if.valid;
      if (s2_free) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_if.valid) s1_raw_q <= in_if.data;
    if (s2_free && s1_vld_q) s2_q <= conv;
  end

  logic [31:0] masked;
  always_comb begin
    case (src)
      FMT_F16: masked = {16'd0, s1_raw_q[15:0]};
      FMT_I8:  masked = {24'd0, s1_raw_q[7:0]};
      default: masked = s1_raw_q;
    endcase
  end

  tefc_convert u_conv (.raw_i(masked), .src_i(src), .dst_i(dst), .res_o(conv));

  assign out_if.valid       = s2_vld_q;
  assign out_if.element_out = s2_q.element;
  assign out_if.clamped     = s2_q.clamped;
endmodule

// ----- src/tefc_convert.sv -----
module tefc_convert (
  input  logic [31:0]     raw_i,
  input  tefc_pkg::fmt_e  src_i,
  input  tefc_pkg::fmt_e  dst_i,
  output tefc_pkg::result_t res_o
);
  import tefc_pkg::*;

  logic [31:0] h2s;
  logic [31:0] b2s;
  logic [31:0] mid;
  logic [15:0] s2h;
  logic [7:0]  s2b;
  logic        s2b_flag;

  // float16 -> float32
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [3:0]  h_lz;
  logic [9:0]  h_norm;
  always_comb begin
    h_ex  = raw_i[14:10];
    h_man = raw_i[9:0];
    h_lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        h_lz = 4'(9 - i);
      end
    end
    h_norm = 10'(h_man << (h_lz + 4'd1));
    if (h_ex == 5'd0) begin
      if (h_man == 10'd0) begin
        h2s = {raw_i[15], 31'd0};
      end else begin
        h2s = {raw_i[15], 8'(BiasDiff + 8'd1 - 8'(h_lz) - 8'd1), h_norm, 13'd0};
      end
    end else if (h_ex == 5'h1f) begin
      h2s = {raw_i[15], 8'hff, h_man, 13'd0};
    end else begin
      h2s = {raw_i[15], 8'(BiasDiff + 8'(h_ex)), h_man, 13'd0};
    end
  end

  // int8 -> float32
  logic [7:0] b_mag;
  logic [2:0] b_p;
  logic [22:0] b_man;
  always_comb begin
    b_mag = raw_i[7] ? 8'(8'd0 - raw_i[7:0]) : raw_i[7:0];
    b_p   = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (b_mag[i]) begin
        b_p = 3'(i);
      end
    end
    b_man = 23'({b_mag, 15'd0} << (5'd8 - 5'(b_p)));
    if (raw_i[7:0] == 8'd0) begin
      b2s = 32'd0;
    end else begin
      b2s = {raw_i[7], 8'(F32ExpBias + 8'(b_p)), b_man};
    end
  end

  always_comb begin
    case (src_i)
      FMT_F16: mid = h2s;
      FMT_I8:  mid = b2s;
      default: mid = raw_i;
    endcase
  end

  // float32 -> float16
  logic [7:0] m_ex;
  always_comb begin
    m_ex = mid[30:23];
    if (m_ex <= BiasDiff) begin
      s2h = {mid[31], 15'd0};
    end else if (m_ex >= 8'd143) begin
      s2h = {mid[31], 15'h7c00};
    end else begin
      s2h = {mid[31], 5'(m_ex - BiasDiff), mid[22:13]};
    end
  end

  // float32 -> int8
  logic [8:0]  i_mag;
  logic [2:0]  i_sh;
  logic [23:0] i_full;
  always_comb begin
    i_sh   = 3'(m_ex - F32ExpBias);
    i_full = {1'b1, mid[22:0]} >> (5'd23 - 5'(i_sh));
    if (m_ex < F32ExpBias) begin
      i_mag = 9'd0;
    end else if (m_ex >= 8'd135) begin
      i_mag = 9'd256;
    end else begin
      i_mag = i_full[8:0];
    end
    s2b_flag = 1'b0;
    if (m_ex == 8'hff && mid[22:0] != 23'd0) begin
      s2b_flag = 1'b1;
      s2b = 8'd0;
    end else if (!mid[31]) begin
      if (i_mag > 9'd127) begin
        s2b_flag = 1'b1;
        s2b = 8'h7f;
      end else begin
        s2b = i_mag[7:0];
      end
    end else if (i_mag > 9'd128) begin
      s2b_flag = 1'b1;
      s2b = 8'h80;
    end else begin
      s2b = 8'(8'd0 - i_mag[7:0]);
    end
  end

  always_comb begin
    res_o.clamped = 1'b0;
    if (src_i == dst_i) begin
      res_o.element = raw_i;
    end else begin
      case (dst_i)
        FMT_F16: res_o.element = {16'd0, s2h};
        FMT_I8: begin
          res_o.element = {24'd0, s2b};
          res_o.clamped = s2b_flag;
        end
        default: res_o.element = mid;
      endcase
    end
  end
endmodule

// ----- src/tefc_checker.sv -----
module tefc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_element,
  input logic        out_clamped
);
  // clamped only comes with an int8 result
  a_clamp_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_clamped |-> out_element[31:8] == 24'd0)
    else $error("clamped with wide result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_element))
    else $error("result dropped under stall");

  // a free output never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && out_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after two cycles");
endmodule

bind tensor_element_format_converter tefc_sva u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_element(out_if.element_out), .out_clamped(out_if.clamped)
);
